[rtl/core/fdce_pkg.sv]
// Shared types, codes and constants of the FAT directory chain engine.
`timescale 1ns / 1ps
`default_nettype none
package fdce_pkg;

  localparam int DIR_ENTRIES_DEF  = 16;
  localparam int FAT_BLOCKS_DEF   = 64;
  localparam int SECTOR_BYTES_DEF = 512;
  localparam int NAME_CHARS_DEF   = 8;

  localparam int NAME_W     = 64;
  localparam int PTR_W      = 7;   // block pointer incl. end marker
  localparam int SIZE_W     = 16;
  localparam int BYTES_W    = 15;
  localparam int DIR_ADDR_W = 8;   // covers the largest directory
  localparam int BLK_ADDR_W = 6;   // covers the largest table

  localparam logic [PTR_W-1:0]  END_MARK = 7'd127;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 16'hFFFF;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELETE = 3'd1,
    OP_RENAME = 3'd2,
    OP_APPEND = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_DIR_FULL  = 3'd3,
    ST_NO_BLOCK  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DISP,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_FIN,
    S_APP_FIND,
    S_APP_LINK,
    S_APP_WB,
    S_RD_RD,
    S_RD_EMIT
  } state_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    ptr_t              first;
    ptr_t              last;
    logic [SIZE_W-1:0] size;
  } dir_entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [DIR_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [DIR_ADDR_W-1:0] wr_addr;
    dir_entry_t            wr_data;
    logic                  set_use;
    logic                  clr_use;
    logic [DIR_ADDR_W-1:0] use_addr;
  } dir_cmd_t;

  typedef struct packed {
    logic                  rd_en;
    logic [BLK_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [BLK_ADDR_W-1:0] wr_addr;
    ptr_t                  wr_data;
    logic                  set_used;
    logic                  clr_used;
    logic [BLK_ADDR_W-1:0] used_addr;
  } fat_cmd_t;

endpackage
`default_nettype wire

[rtl/core/fdce_if.sv]
// Command and result channel interfaces of the FAT directory chain engine.
`timescale 1ns / 1ps
`default_nettype none
interface fdce_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] file_name;
  logic [63:0] new_name;
  logic [14:0] byte_count;
  modport source (output valid, op, file_name, new_name, byte_count, input ready);
  modport sink   (input valid, op, file_name, new_name, byte_count, output ready);
endinterface

interface fdce_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] block_number;
  logic       block_present;
  logic       last_of_run;
  modport source (output valid, status, block_number, block_present, last_of_run,
                  input ready);
  modport sink   (input valid, status, block_number, block_present, last_of_run,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/fat_directory_chain_engine.sv]
// Top level: command sequencer of the FAT directory chain engine.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------
//  in_chan   | in  | valid/ready   | op, file_name, new_name, byte_count
//  out_chan  | out | valid/ready   | status, block_number, block_present,
//            |     |               | last_of_run
//
// One command at a time. Every valid command first scans the directory, one slot
// per cycle, then: create and rename finish in the dispatch state, delete reads
// and frees each chain block in turn and then clears the entry, append finds a
// free block and links it, block by block, and writes the entry back unless the
// table is full at the first search, read reads each next pointer and emits the block.
// Reset clears both stores at once through the in-use and used flags.
// A stalled result holds the sequencer only when another result must be emitted.
`timescale 1ns / 1ps
`default_nettype none
module fat_directory_chain_engine #(
  parameter int DIR_ENTRIES  = fdce_pkg::DIR_ENTRIES_DEF,
  parameter int FAT_BLOCKS   = fdce_pkg::FAT_BLOCKS_DEF,
  parameter int SECTOR_BYTES = fdce_pkg::SECTOR_BYTES_DEF,
  parameter int NAME_CHARS   = fdce_pkg::NAME_CHARS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  fdce_cmd_if.sink  in_chan,
  fdce_res_if.source out_chan
);
  import fdce_pkg::*;

  localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int CW = $clog2(FAT_BLOCKS+1);
  localparam logic [BYTES_W-1:0] SB_L     = BYTES_W'(SECTOR_BYTES);
  localparam ptr_t               FAT_L    = PTR_W'(FAT_BLOCKS);
  localparam ptr_t               FAT_M1_L = PTR_W'(FAT_BLOCKS-1);

  // name cut at first zero character and at NAME_CHARS characters
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic              go;
    r  = '0;
    go = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i >= NAME_CHARS || n[8*i +: 8] == 8'd0) go = 1'b0;
      if (go) r[8*i +: 8] = n[8*i +: 8];
    end
    return r;
  endfunction

  // stores
  dir_cmd_t               dcmd;
  fat_cmd_t               fcmd;
  dir_entry_t             dir_rd;
  logic [DIR_ENTRIES-1:0] dir_use;
  ptr_t                   fat_rd;
  logic [FAT_BLOCKS-1:0]  fat_used;
  logic [CW-1:0]          used_cnt;

  fdce_dir_store #(.DIR_ENTRIES(DIR_ENTRIES)) u_dir (
    .clk(clk), .rst_n(rst_n), .cmd(dcmd), .rd_data(dir_rd), .in_use(dir_use)
  );

  fdce_fat_store #(.FAT_BLOCKS(FAT_BLOCKS)) u_fat (
    .clk(clk), .rst_n(rst_n), .cmd(fcmd), .rd_next(fat_rd), .used(fat_used),
    .used_cnt(used_cnt)
  );

  // registers
  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt, nname_r, nname_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt, rem_r, rem_nxt;
  logic [DW:0]         sc_r, sc_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [DW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                found_r, found_nxt, nfound_r, nfound_nxt;
  logic                free_found_r, free_found_nxt;
  logic [DW-1:0]       s_r, s_nxt, free_idx_r, free_idx_nxt;
  dir_entry_t          ent_r, ent_nxt;
  ptr_t                b_r, b_nxt, k_r, k_nxt, p_r, p_nxt;
  logic                upd_r, upd_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [5:0]          out_blk_r, out_blk_nxt;
  logic                out_pres_r, out_pres_nxt, out_last_r, out_last_nxt;

  // emission request from the sequencer
  logic    emit_ok, emit;
  status_t e_st;
  ptr_t    e_blk;
  logic    e_pres, e_last;

  logic        in_acc, op_ok;
  logic        iu, final_blk, fail_blk;
  logic [16:0] size_sum;

  assign emit_ok   = !out_valid_r || out_chan.ready;
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign op_ok     = (in_chan.op <= 3'(OP_READ));
  assign iu        = dir_use[cmp_idx_r];
  assign final_blk = (rem_r <= SB_L);
  assign fail_blk  = !final_blk && (used_cnt == CW'(FAT_BLOCKS));
  assign size_sum  = {1'b0, ent_r.size} + 17'(bytes_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_acc && op_ok) state_nxt = S_SCAN;
      S_SCAN:     if (cmp_vld_r && cmp_idx_r == DW'(DIR_ENTRIES-1)) state_nxt = S_DISP;
      S_DISP: begin
        if (op_r == OP_CREATE || !found_r) begin
          if (emit_ok) state_nxt = S_IDLE;
        end else begin
          unique case (op_r)
            OP_DELETE: state_nxt = S_DEL_RD;
            OP_RENAME: if (emit_ok) state_nxt = S_IDLE;
            OP_APPEND: begin
              if (bytes_r != '0) state_nxt = S_APP_FIND;
              else if (emit_ok) state_nxt = S_IDLE;
            end
            OP_READ: begin
              if (ent_r.first < FAT_L) state_nxt = S_RD_RD;
              else if (emit_ok) state_nxt = S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DEL_RD:   state_nxt = (b_r < FAT_L && k_r < FAT_L) ? S_DEL_WR : S_DEL_FIN;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_DEL_FIN:  if (emit_ok) state_nxt = S_IDLE;
      S_APP_FIND: begin
        if (used_cnt == CW'(FAT_BLOCKS)) begin
          if (emit_ok) state_nxt = S_IDLE;
        end else if (!fat_used[p_r[$clog2(FAT_BLOCKS)-1:0]]) begin
          state_nxt = S_APP_LINK;
        end
      end
      S_APP_LINK: if (emit_ok) state_nxt = (final_blk || fail_blk) ? S_APP_WB : S_APP_FIND;
      S_APP_WB:   state_nxt = S_IDLE;
      S_RD_RD:    state_nxt = S_RD_EMIT;
      S_RD_EMIT: begin
        if (emit_ok) begin
          state_nxt = (fat_rd >= FAT_L || k_r == FAT_M1_L) ? S_IDLE : S_RD_RD;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_nxt = op_r;  name_nxt = name_r;  nname_nxt = nname_r;  bytes_nxt = bytes_r;
    rem_nxt = rem_r;  sc_nxt = sc_r;  cmp_vld_nxt = 1'b0;  cmp_idx_nxt = cmp_idx_r;
    found_nxt = found_r;  nfound_nxt = nfound_r;  free_found_nxt = free_found_r;
    s_nxt = s_r;  free_idx_nxt = free_idx_r;  ent_nxt = ent_r;
    b_nxt = b_r;  k_nxt = k_r;  p_nxt = p_r;  upd_nxt = upd_r;
    dcmd = '0;  fcmd = '0;
    emit = 1'b0;  e_st = ST_OK;  e_blk = '0;  e_pres = 1'b0;  e_last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        op_nxt         = op_t'(in_chan.op);
        name_nxt       = norm_name(in_chan.file_name);
        nname_nxt      = norm_name(in_chan.new_name);
        bytes_nxt      = in_chan.byte_count;
        sc_nxt         = '0;
        found_nxt      = 1'b0;
        nfound_nxt     = 1'b0;
        free_found_nxt = 1'b0;
      end
      S_SCAN: begin
        if (sc_r < (DW+1)'(DIR_ENTRIES)) begin
          dcmd.rd_en   = 1'b1;
          dcmd.rd_addr = DIR_ADDR_W'(sc_r[DW-1:0]);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = sc_r[DW-1:0];
          sc_nxt       = sc_r + (DW+1)'(1);
        end
        if (cmp_vld_r) begin
          if (iu && dir_rd.name == name_r && !found_r) begin
            found_nxt = 1'b1;
            s_nxt     = cmp_idx_r;
            ent_nxt   = dir_rd;
          end
          if (iu && dir_rd.name == nname_r) nfound_nxt = 1'b1;
          if (!iu && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
        end
      end
      S_DISP: begin
        b_nxt   = ent_r.first;
        k_nxt   = '0;
        p_nxt   = '0;
        rem_nxt = bytes_r;
        if (op_r == OP_CREATE) begin
          emit = emit_ok;
          if (found_r) begin
            e_st = ST_EXISTS;
          end else if (free_found_r) begin
            e_st              = ST_OK;
            dcmd.wr_en        = emit_ok;
            dcmd.wr_addr      = DIR_ADDR_W'(free_idx_r);
            dcmd.wr_data      = '{name: name_r, first: END_MARK, last: END_MARK,
                                  size: '0};
            dcmd.set_use      = emit_ok;
            dcmd.use_addr     = DIR_ADDR_W'(free_idx_r);
          end else begin
            e_st = ST_DIR_FULL;
          end
        end else if (!found_r) begin
          emit = emit_ok;
          e_st = ST_NOT_FOUND;
        end else begin
          case (op_r)
            OP_RENAME: begin
              emit = emit_ok;
              if (nfound_r) begin
                e_st = ST_EXISTS;
              end else begin
                dcmd.wr_en        = emit_ok;
                dcmd.wr_addr      = DIR_ADDR_W'(s_r);
                dcmd.wr_data      = ent_r;
                dcmd.wr_data.name = nname_r;
              end
            end
            OP_APPEND: if (bytes_r == '0) emit = emit_ok;
            OP_READ:   if (ent_r.first >= FAT_L) emit = emit_ok;
            default: ;
          endcase
        end
      end
      S_DEL_RD: begin
        if (b_r < FAT_L && k_r < FAT_L) begin
          fcmd.rd_en   = 1'b1;
          fcmd.rd_addr = BLK_ADDR_W'(b_r);
        end
      end
      S_DEL_WR: begin
        fcmd.wr_en     = 1'b1;
        fcmd.wr_addr   = BLK_ADDR_W'(b_r);
        fcmd.wr_data   = END_MARK;
        fcmd.clr_used  = 1'b1;
        fcmd.used_addr = BLK_ADDR_W'(b_r);
        b_nxt          = fat_rd;
        k_nxt          = k_r + PTR_W'(1);
      end
      S_DEL_FIN: begin
        emit          = emit_ok;
        dcmd.clr_use  = emit_ok;
        dcmd.use_addr = DIR_ADDR_W'(s_r);
      end
      S_APP_FIND: begin
        if (used_cnt == CW'(FAT_BLOCKS)) begin
          emit = emit_ok;
          e_st = ST_NO_BLOCK;
        end else if (fat_used[p_r[$clog2(FAT_BLOCKS)-1:0]]) begin
          p_nxt = p_r + PTR_W'(1);
        end else begin
          b_nxt          = p_r;
          fcmd.wr_en     = 1'b1;
          fcmd.wr_addr   = BLK_ADDR_W'(p_r);
          fcmd.wr_data   = END_MARK;
          fcmd.set_used  = 1'b1;
          fcmd.used_addr = BLK_ADDR_W'(p_r);
        end
      end
      S_APP_LINK: begin
        emit   = emit_ok;
        e_st   = fail_blk ? ST_NO_BLOCK : ST_OK;
        e_blk  = b_r;
        e_pres = 1'b1;
        e_last = final_blk || fail_blk;
        if (emit_ok) begin
          if (ent_r.first >= FAT_L || ent_r.last >= FAT_L) begin
            ent_nxt.first = b_r;
          end else begin
            fcmd.wr_en   = 1'b1;
            fcmd.wr_addr = BLK_ADDR_W'(ent_r.last);
            fcmd.wr_data = b_r;
          end
          ent_nxt.last = b_r;
          rem_nxt      = final_blk ? '0 : rem_r - SB_L;
          upd_nxt      = final_blk;
        end
      end
      S_APP_WB: begin
        dcmd.wr_en   = 1'b1;
        dcmd.wr_addr = DIR_ADDR_W'(s_r);
        dcmd.wr_data = ent_r;
        if (upd_r) begin
          dcmd.wr_data.size = size_sum[16] ? SIZE_MAX : size_sum[15:0];
        end
      end
      S_RD_RD: begin
        fcmd.rd_en   = 1'b1;
        fcmd.rd_addr = BLK_ADDR_W'(b_r);
      end
      S_RD_EMIT: begin
        emit   = emit_ok;
        e_blk  = b_r;
        e_pres = 1'b1;
        e_last = (fat_rd >= FAT_L) || (k_r == FAT_M1_L);
        if (emit_ok) begin
          b_nxt = fat_rd;
          k_nxt = k_r + PTR_W'(1);
        end
      end
      default: ;
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
    out_st_nxt    = emit ? e_st : out_st_r;
    out_blk_nxt   = emit ? e_blk[5:0] : out_blk_r;
    out_pres_nxt  = emit ? e_pres : out_pres_r;
    out_last_nxt  = emit ? e_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  name_r <= name_nxt;  nname_r <= nname_nxt;  bytes_r <= bytes_nxt;
    rem_r <= rem_nxt;  sc_r <= sc_nxt;  cmp_idx_r <= cmp_idx_nxt;
    found_r <= found_nxt;  nfound_r <= nfound_nxt;  free_found_r <= free_found_nxt;
    s_r <= s_nxt;  free_idx_r <= free_idx_nxt;  ent_r <= ent_nxt;
    b_r <= b_nxt;  k_r <= k_nxt;  p_r <= p_nxt;  upd_r <= upd_nxt;
    out_st_r <= out_st_nxt;  out_blk_r <= out_blk_nxt;
    out_pres_r <= out_pres_nxt;  out_last_r <= out_last_nxt;
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_st_r;
  assign out_chan.block_number  = out_blk_r;
  assign out_chan.block_present = out_pres_r;
  assign out_chan.last_of_run   = out_last_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt <= CW'(FAT_BLOCKS))
    else $error("used block count out of range");

  a_link_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APP_LINK |-> fat_used[b_r[$clog2(FAT_BLOCKS)-1:0]])
    else $error("linked block not marked used");

  a_no_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pres_r |-> out_blk_r == '0 && out_last_r)
    else $error("blockless transaction malformed");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op_ok |=> state_r == S_SCAN)
    else $error("command not followed by directory scan");
endmodule
`default_nettype wire

[rtl/core/fdce_dir_store.sv]
// Directory store: entry memory with registered read, in-use flags in flops.
`timescale 1ns / 1ps
`default_nettype none
module fdce_dir_store #(
  parameter int DIR_ENTRIES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fdce_pkg::dir_cmd_t     cmd,
  output fdce_pkg::dir_entry_t        rd_data,
  output logic [DIR_ENTRIES-1:0]      in_use
);
  import fdce_pkg::*;

  localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

  dir_entry_t             mem [DIR_ENTRIES];
  dir_entry_t             rd_r;
  logic [DIR_ENTRIES-1:0] use_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[DW-1:0]] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[cmd.rd_addr[DW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
    end else if (cmd.set_use) begin
      use_r[cmd.use_addr[DW-1:0]] <= 1'b1;
    end else if (cmd.clr_use) begin
      use_r[cmd.use_addr[DW-1:0]] <= 1'b0;
    end
  end

  assign rd_data = rd_r;
  assign in_use  = use_r;
endmodule
`default_nettype wire

[rtl/core/fdce_fat_store.sv]
// Allocation table store: next-pointer memory, used flags and used-block count.
`timescale 1ns / 1ps
`default_nettype none
module fdce_fat_store #(
  parameter int FAT_BLOCKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fdce_pkg::fat_cmd_t            cmd,
  output fdce_pkg::ptr_t                     rd_next,
  output logic [FAT_BLOCKS-1:0]              used,
  output logic [$clog2(FAT_BLOCKS+1)-1:0]    used_cnt
);
  import fdce_pkg::*;

  localparam int BW = $clog2(FAT_BLOCKS);
  localparam int CW = $clog2(FAT_BLOCKS+1);

  ptr_t                  mem [FAT_BLOCKS];
  ptr_t                  rd_r;
  logic [FAT_BLOCKS-1:0] used_r;
  logic [CW-1:0]         cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[BW-1:0]] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[cmd.rd_addr[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.set_used) begin
      used_r[cmd.used_addr[BW-1:0]] <= 1'b1;
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.clr_used) begin
      used_r[cmd.used_addr[BW-1:0]] <= 1'b0;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign rd_next  = rd_r;
  assign used     = used_r;
  assign used_cnt = cnt_r;
endmodule
`default_nettype wire
